### rtl/core/lse_pkg.sv
// Shared types, constants and codes of the LSB payload extractor.
package lse_pkg;

	localparam int unsigned MAX_PAYLOAD_BYTES = 100000;
	localparam int unsigned NUM_LANES = 3;
	localparam int unsigned HEADER_BITS = 32;

	// Frame phases
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_BYTE   = 2'd0;
	localparam logic [1:0] ST_NO_SIG = 2'd1;
	localparam logic [1:0] ST_SHORT  = 2'd2;

	typedef struct packed {
		logic [1:0]  phase;
		logic [5:0]  cnt;
		logic [7:0]  shift;
		logic [31:0] length;
	} lse_state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [1:0] status;
		logic       last;
	} lse_res_t;

	localparam lse_state_t STATE_RESET = '{phase: PH_HEADER, cnt: '0, shift: '0, length: '0};
	localparam lse_res_t   RES_NONE    = '{valid: 1'b0, data: '0, status: ST_BYTE, last: 1'b0};

endpackage

### rtl/core/lse_lane.sv
// One carrier-bit lane: advances the header/payload state by a single bit.
module lse_lane (
	input  lse_pkg::lse_state_t st_in,
	input  logic                carrier_bit,
	input  logic [25:0]         capacity,
	output lse_pkg::lse_state_t st_out,
	output lse_pkg::lse_res_t   res
);
	import lse_pkg::*;

	logic [7:0]  sh;
	logic [5:0]  cnt_nxt;
	logic [1:0]  slot;
	logic [31:0] len_hdr;
	logic [34:0] need;
	logic        bad;
	logic [31:0] len_dec;

	assign sh      = {st_in.shift[6:0], carrier_bit};
	assign cnt_nxt = st_in.cnt + 6'd1;
	assign slot    = 2'(cnt_nxt[5:3] - 3'd1);
	assign len_dec = st_in.length - 32'd1;

	always_comb begin
		len_hdr = st_in.length;
		if (cnt_nxt[2:0] == 3'd0) begin
			len_hdr[slot*8 +: 8] = sh;
		end
	end

	assign need = {len_hdr, 3'b000} + 35'd32;
	assign bad  = (len_hdr == 32'd0) || (len_hdr > 32'(MAX_PAYLOAD_BYTES))
		|| (need > {9'd0, capacity});

	always_comb begin
		st_out = st_in;
		res    = RES_NONE;
		case (st_in.phase)
			PH_HEADER: begin
				st_out.cnt    = cnt_nxt;
				st_out.length = len_hdr;
				st_out.shift  = (cnt_nxt[2:0] == 3'd0) ? 8'd0 : sh;
				if (cnt_nxt >= 6'(HEADER_BITS)) begin
					st_out.cnt   = '0;
					st_out.shift = '0;
					if (bad) begin
						res.valid    = 1'b1;
						res.status   = ST_NO_SIG;
						res.last     = 1'b1;
						st_out.phase = PH_DONE;
					end else begin
						st_out.phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				st_out.cnt   = cnt_nxt;
				st_out.shift = sh;
				if (cnt_nxt[3]) begin
					res.valid     = 1'b1;
					res.data      = sh;
					res.status    = ST_BYTE;
					res.last      = (st_in.length == 32'd1);
					st_out.length = len_dec;
					st_out.cnt    = '0;
					st_out.shift  = '0;
					if (len_dec == 32'd0) begin
						st_out.phase = PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/lse_merge.sv
// Merges the lane results of one pixel and applies the end-of-frame restart.
module lse_merge (
	input  lse_pkg::lse_state_t              lane_st,
	input  lse_pkg::lse_res_t [2:0]          lane_res,
	input  logic                             frame_end,
	output lse_pkg::lse_state_t              st_nxt,
	output lse_pkg::lse_res_t                res
);
	import lse_pkg::*;

	lse_res_t any;

	// At most one lane produces a result per pixel, so an OR merge is exact.
	assign any = lane_res[0] | lane_res[1] | lane_res[2];

	always_comb begin
		res    = any;
		st_nxt = lane_st;
		if (frame_end) begin
			st_nxt = STATE_RESET;
			if (lane_st.phase == PH_HEADER && !any.valid) begin
				res        = RES_NONE;
				res.valid  = 1'b1;
				res.status = ST_SHORT;
				res.last   = 1'b1;
			end
		end
	end

endmodule

### rtl/core/lsb_payload_extractor.sv
// Top level of the LSB payload extractor: lanes, merge, frame counter and output skid.
//
//  Channel   Direction  Signals                      Contents (lowest bits first)
//  s_axis    in         tvalid/tready/tdata[23:0]    red, green, blue bytes of one pixel
//  m_axis    out        tvalid/tready/tdata/tuser/   payload byte; tuser = status;
//                       tlast                        tlast marks final byte or status
//  cfg       in         cfg_we/cfg_wdata[23:0]       pixel count of the image
//
// One pixel request is taken every cycle while s_axis_tready is high. Its three carrier bits
// pass through three chained lanes and the merge in the same cycle, so the frame state loop
// closes combinationally; a result enters the output register, or the skid stage if stalled.
// Reset sets the pixel count to one and the frame state to reading the header.
// The output side has a register and a skid stage; s_axis_tready falls only while the skid
// stage is occupied, that is after the output has been stalled with two results pending.
module lsb_payload_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red_byte [7:0], green_byte [15:8], blue_byte [23:16]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // payload_byte [7:0]
	output logic [1:0]  m_axis_tuser,   // status [1:0]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata       // pixel_count [23:0]
);
	import lse_pkg::*;

	logic [23:0] pixel_count_q;
	logic [25:0] capacity_q;      // three carrier bits per pixel
	logic [23:0] pixel_index_q;
	lse_state_t  state_q;

	lse_state_t          lane_st [0:3];
	lse_res_t   [2:0]    lane_res;
	logic       [2:0]    carrier;
	lse_state_t          st_nxt;
	lse_res_t            res;
	logic                frame_end;
	logic                accept;

	lse_res_t out_q;
	lse_res_t skid_q;

	// Configuration register; the capacity is precomputed so the header check is a compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= 24'd1;
			capacity_q    <= 26'd3;
		end else if (cfg_we) begin
			pixel_count_q <= cfg_wdata;
			capacity_q    <= {1'b0, cfg_wdata, 1'b0} + {2'b00, cfg_wdata};
		end
	end

	assign carrier = {s_axis_tdata[16], s_axis_tdata[8], s_axis_tdata[0]};
	assign lane_st[0] = state_q;

	// Red, green and blue lanes, each consuming one carrier bit in stream order.
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		lse_lane u_lane (
			.st_in       (lane_st[i]),
			.carrier_bit (carrier[i]),
			.capacity    (capacity_q),
			.st_out      (lane_st[i+1]),
			.res         (lane_res[i])
		);
	end

	// The frame ends once this pixel brings the index up to the configured count.
	assign frame_end = ({1'b0, pixel_index_q} + 25'd1) >= {1'b0, pixel_count_q};

	lse_merge u_merge (
		.lane_st   (lane_st[3]),
		.lane_res  (lane_res),
		.frame_end (frame_end),
		.st_nxt    (st_nxt),
		.res       (res)
	);

	assign s_axis_tready = !skid_q.valid;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= STATE_RESET;
			pixel_index_q <= '0;
		end else if (accept) begin
			state_q       <= st_nxt;
			pixel_index_q <= frame_end ? 24'd0 : pixel_index_q + 24'd1;
		end
	end

	// Output register with a skid stage behind it. A new result goes to the skid stage only
	// when the output register is full and stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= RES_NONE;
			skid_q <= RES_NONE;
		end else if (!out_q.valid || m_axis_tready) begin
			if (skid_q.valid) begin
				out_q        <= skid_q;
				skid_q.valid <= 1'b0;
			end else begin
				out_q <= '{valid: accept && res.valid, data: res.data, status: res.status,
					last: res.last};
			end
		end else if (accept && res.valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_q.valid;
	assign m_axis_tdata  = out_q.data;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.last;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q.valid |-> out_q.valid)
		else $error("skid stage holds a result while the output register is empty");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_BYTE) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
		else $error("status result without last or with nonzero data");

	a_header_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_HEADER) |-> (state_q.cnt < 6'(HEADER_BITS)))
		else $error("header bit count overran");

	a_payload_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_PAYLOAD) |-> (state_q.cnt < 6'd8 && state_q.length != 32'd0))
		else $error("payload phase with bad bit count or no bytes left");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_end) |=> (pixel_index_q == 24'd0 && state_q.phase == PH_HEADER))
		else $error("frame end did not restart the frame state");
`endif

endmodule
